### rtl/dbm_pkg.sv
package dbm_pkg;

    localparam int CHANNELS_DEF   = 2;
    localparam int TANH_DEPTH_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int DRIVE_W  = 16;
    localparam int MIX_W    = 17;
    localparam int Y_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [DRIVE_W-1:0] DRIVE_THRESHOLD = DRIVE_W'(65);
    localparam logic [MIX_W-1:0]   MIX_FULL        = MIX_W'(65536);

    localparam logic signed [COEF_W-1:0] COEF_B0_RST = COEF_W'(1048576);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0      = 3'd0,
        REG_COEF_B1      = 3'd1,
        REG_COEF_B2      = 3'd2,
        REG_COEF_A1      = 3'd3,
        REG_COEF_A2      = 3'd4,
        REG_DRIVE_AMOUNT = 3'd5,
        REG_WET_MIX      = 3'd6
    } t_reg_idx;

endpackage

### rtl/dbm_in_if.sv
interface dbm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   channel;
    logic signed [dbm_pkg::SAMPLE_W-1:0]    sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

### rtl/dbm_out_if.sv
interface dbm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   channel_out;
    logic signed [dbm_pkg::SAMPLE_W-1:0]    sample_out;

    modport source (output valid, output channel_out, output sample_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

### rtl/drive_biquad_mix_filter.sv
// Drive, biquad and dry/wet mix for a multi-channel Q1.15 stream, one sample at a
// time. Drive is on when drive_amount is above 65 and adds the gain, clamp, table
// index, table read and shaping steps ahead of the biquad. The result waits in the
// output step while the output register is full. The next sample is accepted only
// after the result is loaded, once the sequencer is back in idle. The order is set by the
// single shared 25x25 multiplier, which steps through the gain, table index, five biquad
// products and the mix product one per cycle, and by the registered read of the
// per-channel history memory. History is cleared at reset through per-channel valid
// bits, so no clearing pass is needed. The tanh table is a registered ROM of
// TANH_TABLE_DEPTH entries. Configuration writes are meant to happen only while no
// sample is in flight.
module drive_biquad_mix_filter #(
    parameter int CHANNELS         = dbm_pkg::CHANNELS_DEF,
    parameter int TANH_TABLE_DEPTH = dbm_pkg::TANH_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbm_in_if.sink                          i_in,
    dbm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [dbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dbm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW    = $clog2(TANH_TABLE_DEPTH);
    localparam int SW    = dbm_pkg::SAMPLE_W;
    localparam int YW    = dbm_pkg::Y_W;
    localparam int MW    = dbm_pkg::MUL_W;
    localparam int PW    = dbm_pkg::PROD_W;
    localparam int AC    = dbm_pkg::ACC_W;
    localparam int HW    = 2 * SW + 2 * YW;
    localparam int GAIN_W = 21;

    typedef logic [SW-1:0] t_rom [TANH_TABLE_DEPTH];
    typedef logic [HW-1:0] t_hist;

    // shift-subtract quotient, used only while the table is built
    function automatic logic [63:0] f_udiv(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] num;
        logic [63:0] den;
        one = 64'd1 << 28;
        for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
            y    = f_udiv(64'(2 * k) << 28, 64'(TANH_TABLE_DEPTH - 1));
            e    = one;
            term = one;
            for (int n = 1; n <= 40; n++) begin
                term = f_udiv((term * y) >> 28, 64'(n));
                e    = e + term;
            end
            num    = e - one;
            den    = e + one;
            rom[k] = SW'(f_udiv(num * 64'd65536 + den, 64'd2 * den));
        end
        return rom;
    endfunction

    localparam t_rom TANH_ROM = f_build_rom();

    typedef enum logic [3:0] {
        S_IDLE, S_GAIN, S_CLMP, S_IDXM, S_ROM, S_SHAPE,
        S_B0, S_B1, S_B2, S_A1, S_A2, S_Y, S_SAT, S_MIX, S_OUT
    } t_state;

    // configuration
    logic signed [dbm_pkg::COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [dbm_pkg::DRIVE_W-1:0]       r_drive;
    logic [dbm_pkg::MIX_W-1:0]         r_mix;

    // datapath
    t_state                 r_state;
    logic                   r_ch;
    logic [AW-1:0]          r_addr;
    logic signed [SW-1:0]   r_s;
    logic signed [SW-1:0]   r_x;
    logic [SW:0]            r_mag;
    logic                   r_neg;
    logic [SW-1:0]          r_tanh;
    logic signed [PW-1:0]   r_prod;
    logic signed [AC-1:0]   r_acc;
    logic signed [YW-1:0]   r_y;
    logic                   r_out_valid;
    logic                   r_out_ch;
    logic signed [SW-1:0]   r_out_sample;

    // history memory
    t_hist                  r_mem [CHANNELS];
    t_hist                  r_rd;
    logic                   r_rd_valid;
    logic [CHANNELS-1:0]    r_hvalid;

    logic [AW-1:0]          in_addr;
    logic                   in_xfer;
    t_hist                  hist;
    logic signed [SW-1:0]   h_x1, h_x2;
    logic signed [YW-1:0]   h_y1, h_y2;
    logic [GAIN_W-1:0]      gain;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [PW-16-1:0] v_full;
    logic signed [SW-1:0]   v_clmp;
    logic [PW-1:0]          idx_full;
    logic [IW-1:0]          idx;
    logic signed [AC-1:0]   acc_rnd;
    logic signed [AC-20-1:0] y_full;
    logic signed [YW-1:0]   y_sat;
    logic [dbm_pkg::MIX_W-1:0] mix_eff;
    logic signed [PW-16-1:0] o_full;
    logic signed [SW-1:0]   o_sat;
    logic                   out_free;

    assign in_addr = (CHANNELS > 1) ? AW'(i_in.channel) : '0;
    assign in_xfer = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign hist = r_rd_valid ? r_rd : '0;
    assign h_x1 = hist[HW-1 -: SW];
    assign h_x2 = hist[HW-SW-1 -: SW];
    assign h_y1 = hist[2*YW-1 -: YW];
    assign h_y2 = hist[YW-1:0];

    assign gain = GAIN_W'(65536) + GAIN_W'(r_drive) * GAIN_W'(10);
    assign mix_eff = r_mix[dbm_pkg::MIX_W-1] ? dbm_pkg::MIX_FULL : r_mix;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_GAIN: begin
                mul_a = MW'(r_s);
                mul_b = $signed(MW'(gain));
            end
            S_IDXM: begin
                mul_a = $signed(MW'(r_mag));
                mul_b = MW'(TANH_TABLE_DEPTH - 1);
            end
            S_B0: begin
                mul_a = MW'(r_b0);
                mul_b = MW'(r_x);
            end
            S_B1: begin
                mul_a = MW'(r_b1);
                mul_b = MW'(h_x1);
            end
            S_B2: begin
                mul_a = MW'(r_b2);
                mul_b = MW'(h_x2);
            end
            S_A1: begin
                mul_a = MW'(r_a1);
                mul_b = -MW'(h_y1);
            end
            S_A2: begin
                mul_a = MW'(r_a2);
                mul_b = -MW'(h_y2);
            end
            S_MIX: begin
                mul_a = MW'(r_y) - MW'(r_x);
                mul_b = $signed(MW'(mix_eff));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // drive clamp and table index
    assign v_full = (PW-16)'(r_prod >>> 16) ;
    always_comb begin
        if (v_full > $signed((PW-16)'(32767))) begin
            v_clmp = SW'(32767);
        end else if (v_full < -$signed((PW-16)'(32768))) begin
            v_clmp = -SW'(32768) ;
        end else begin
            v_clmp = SW'(v_full);
        end
    end

    assign idx_full = ($unsigned(r_prod) + PW'(16384)) >> 15;
    assign idx = (idx_full > PW'(TANH_TABLE_DEPTH - 1)) ? IW'(TANH_TABLE_DEPTH - 1)
                                                        : IW'(idx_full);

    // biquad rounding and saturation
    assign acc_rnd = r_acc + AC'(1 << 19);
    assign y_full  = (AC-20)'(acc_rnd >>> 20);
    always_comb begin
        if (y_full > $signed((AC-20)'((1 << 23) - 1))) begin
            y_sat = YW'((1 << 23) - 1);
        end else if (y_full < -$signed((AC-20)'(1 << 23))) begin
            y_sat = YW'(1 << 23);
        end else begin
            y_sat = YW'(y_full);
        end
    end

    // mix rounding and saturation
    assign o_full = (PW-16)'(r_x) + (PW-16)'((r_prod + PW'(32768)) >>> 16);
    always_comb begin
        if (o_full > $signed((PW-16)'(32767))) begin
            o_sat = SW'(32767);
        end else if (o_full < -$signed((PW-16)'(32768))) begin
            o_sat = -SW'(32768);
        end else begin
            o_sat = SW'(o_full);
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0    <= dbm_pkg::COEF_B0_RST;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_drive <= '0;
            r_mix   <= dbm_pkg::MIX_FULL;
        end else if (i_cfg_we) begin
            unique case (dbm_pkg::t_reg_idx'(i_cfg_idx))
                dbm_pkg::REG_COEF_B0:      r_b0    <= i_cfg_data;
                dbm_pkg::REG_COEF_B1:      r_b1    <= i_cfg_data;
                dbm_pkg::REG_COEF_B2:      r_b2    <= i_cfg_data;
                dbm_pkg::REG_COEF_A1:      r_a1    <= i_cfg_data;
                dbm_pkg::REG_COEF_A2:      r_a2    <= i_cfg_data;
                dbm_pkg::REG_DRIVE_AMOUNT: r_drive <= i_cfg_data[dbm_pkg::DRIVE_W-1:0];
                dbm_pkg::REG_WET_MIX:      r_mix   <= i_cfg_data[dbm_pkg::MIX_W-1:0];
                default: ;
            endcase
        end
    end

    // history memory: read on transfer in, written back once y is known
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd <= r_mem[in_addr];
        end
        if (r_state == S_SAT) begin
            r_mem[r_addr] <= {r_x, h_x1, y_sat, h_y1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid   <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_rd_valid <= r_hvalid[in_addr];
            end
            if (r_state == S_SAT) begin
                r_hvalid[r_addr] <= 1'b1;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // hold mix product while the output stalls
            if (r_state != S_OUT) begin
                r_prod <= mul_p;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ch   <= i_in.channel;
                        r_addr <= in_addr;
                        r_s    <= i_in.sample_in;
                        r_x    <= i_in.sample_in;
                        r_state <= (r_drive > dbm_pkg::DRIVE_THRESHOLD) ? S_GAIN : S_B0;
                    end
                end
                S_GAIN:  r_state <= S_CLMP;
                S_CLMP: begin
                    r_neg   <= v_clmp[SW-1];
                    r_mag   <= v_clmp[SW-1] ? (SW+1)'(-(SW+1)'(v_clmp))
                                            : (SW+1)'(v_clmp);
                    r_state <= S_IDXM;
                end
                S_IDXM:  r_state <= S_ROM;
                S_ROM: begin
                    r_tanh  <= TANH_ROM[idx];
                    r_state <= S_SHAPE;
                end
                S_SHAPE: begin
                    r_x     <= r_neg ? -$signed(r_tanh) : $signed(r_tanh);
                    r_state <= S_B0;
                end
                S_B0: begin
                    r_acc   <= '0;
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_acc   <= r_acc + AC'(r_prod);
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_acc   <= r_acc + AC'(r_prod);
                    r_state <= S_A1;
                end
                S_A1: begin
                    r_acc   <= r_acc + AC'(r_prod);
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_acc   <= r_acc + AC'(r_prod);
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_acc   <= r_acc + AC'(r_prod);
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_y     <= y_sat;
                    r_state <= S_MIX;
                end
                S_MIX:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_out_ch     <= r_ch;
                        r_out_sample <= o_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out_ch;
    assign o_out.sample_out  = r_out_sample;

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_GAIN || r_state == S_B0))
        else $error("sequencer did not start after input transfer");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared outside the output step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready while a sample is in flight");

    a_hist_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SAT) |=> r_hvalid[r_addr])
        else $error("history entry not marked valid after write-back");

endmodule
